>>> src/priority_periodic_task_dispatcher_core_assert.svh
// Assertion macros used by the dispatcher checker
`ifndef PRIORITY_PERIODIC_TASK_DISPATCHER_CORE_ASSERT_SVH
`define PRIORITY_PERIODIC_TASK_DISPATCHER_CORE_ASSERT_SVH

// clocked check, suspended while reset is high
`define PPD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

// clocked check that also holds across reset
`define PPD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("check failed");

`endif

>>> src/ppd_pkg.sv
// Shared types and constants of the periodic task dispatcher
package ppd_pkg;

   localparam int TN_W        = 3;
   localparam int RATE_W      = 10;
   localparam int PRIO_W      = 8;
   localparam int ELAPSED_W   = 16;
   localparam int RES_CNT_W   = 4;
   localparam int MAX_RESULTS = 8;

   localparam logic [26:0]          PERIOD_BASE = 27'd1000;
   localparam logic [ELAPSED_W-1:0] COUNT_MAX   = 16'hFFFF;

   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_ENABLE  = 2'd1;
   localparam logic [1:0] ACT_DISABLE = 2'd2;
   localparam logic [1:0] ACT_TICK    = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   typedef struct packed {
      logic [RATE_W-1:0]    rate;
      logic [PRIO_W-1:0]    prio;
      logic [ELAPSED_W-1:0] elapsed;
   } task_entry_type;

   typedef struct packed {
      logic [TN_W-1:0] task_id;
      logic            dispatched;
      logic [1:0]      status;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type data;
   } out_req_type;

endpackage

>>> src/ppd_ram.sv
// Generic simple dual-port RAM with registered read
module ppd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/ppd_ctrl.sv
// Sequencer: task table and dispatch list read-modify-write over two RAMs
module ppd_ctrl #(
   parameter int MAX_TASKS = 8,
   parameter int TICK_MS   = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic [ppd_pkg::TN_W-1:0]  req_task_number,
   input  logic [ppd_pkg::RATE_W-1:0] req_rate_hz,
   input  logic [ppd_pkg::PRIO_W-1:0] req_priority_req,
   input  logic                      req_start_enabled,
   input  logic                      csr_write_enable,
   input  logic                      csr_write_data,
   input  logic                      out_free,
   output ppd_pkg::out_req_type      out_req
);
   import ppd_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int CW    = (CNT_W > TN_W) ? CNT_W : TN_W;
   localparam int TE_W  = $bits(task_entry_type);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ADD_RD  = 4'd1;
   localparam logic [3:0] S_ADD_TK  = 4'd2;
   localparam logic [3:0] S_ADD_CMP = 4'd3;
   localparam logic [3:0] S_RESULT  = 4'd4;
   localparam logic [3:0] S_TK_RD   = 4'd5;
   localparam logic [3:0] S_TK_TK   = 4'd6;
   localparam logic [3:0] S_TK_EVAL = 4'd7;
   localparam logic [3:0] S_TK_FLSH = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     step_ff, step_in;
   logic [MAX_TASKS-1:0] en_ff, en_in;
   logic                 run_ff, run_in;
   logic                 pend_v_ff, pend_v_in;
   logic [IDX_W-1:0]     pend_id_ff, pend_id_in;
   logic [PRIO_W-1:0]    batch_prio_ff, batch_prio_in;
   logic                 stop_ff, stop_in;
   logic [RES_CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]     ord_t_ff, ord_t_in;
   logic [PRIO_W-1:0]    prio_ff, prio_in;
   rsp_type              res_ff, res_in;

   logic             ord_we;
   logic [IDX_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
   logic             tsk_we;
   logic [IDX_W-1:0] tsk_waddr, tsk_raddr;
   task_entry_type   tsk_wdata;
   logic [TE_W-1:0]  tsk_rdata;

   task_entry_type   entry;
   logic [CNT_W-1:0] stepm1;
   logic [16:0]      sum;
   logic [15:0]      c_new;
   logic [16:0]      cp1;
   logic [26:0]      prod;
   logic             due, conflict, batch_full, take;
   logic             accepted;

   ppd_ram #(.WIDTH(IDX_W), .DEPTH(MAX_TASKS)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   ppd_ram #(.WIDTH(TE_W), .DEPTH(MAX_TASKS)) u_task_ram (
      .clock   (clock),
      .wr_en   (tsk_we),
      .wr_addr (tsk_waddr),
      .wr_data (tsk_wdata),
      .rd_addr (tsk_raddr),
      .rd_data (tsk_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accepted  = req_valid && req_ready;

   always_comb begin
      entry      = task_entry_type'(tsk_rdata);
      stepm1     = step_ff - CNT_W'(1);
      sum        = {1'b0, entry.elapsed} + 17'(TICK_MS);
      c_new      = sum[16] ? COUNT_MAX : sum[15:0];
      cp1        = {1'b0, c_new} + 17'd1;
      prod       = 27'(cp1) * 27'(entry.rate);
      due        = en_ff[ord_t_ff] && (entry.rate != '0) && (prod > PERIOD_BASE) && !stop_ff;
      conflict   = pend_v_ff && (entry.prio != batch_prio_ff);
      batch_full = (cnt_ff >= RES_CNT_W'(MAX_RESULTS));
      take       = due && !conflict && !batch_full;
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      step_in       = step_ff;
      en_in         = en_ff;
      run_in        = csr_write_enable ? csr_write_data : run_ff;
      pend_v_in     = pend_v_ff;
      pend_id_in    = pend_id_ff;
      batch_prio_in = batch_prio_ff;
      stop_in       = stop_ff;
      cnt_in        = cnt_ff;
      ord_t_in      = ord_t_ff;
      prio_in       = prio_ff;
      res_in        = res_ff;
      ord_we        = 1'b0;
      ord_waddr     = step_ff[IDX_W-1:0];
      ord_wdata     = n_ff[IDX_W-1:0];
      ord_raddr     = step_ff[IDX_W-1:0];
      tsk_we        = 1'b0;
      tsk_waddr     = ord_t_ff;
      tsk_wdata     = '{rate: entry.rate, prio: entry.prio, elapsed: c_new};
      tsk_raddr     = ord_t_ff;
      out_req       = '{push: 1'b0, data: res_ff};

      case (state_ff)
         S_IDLE: begin
            if (accepted) begin
               case (req_action)
                  ACT_ADD: begin
                     if (n_ff == CNT_W'(MAX_TASKS)) begin
                        res_in   = '{task_id: '0, dispatched: 1'b0, status: ST_FULL, last: 1'b1};
                        state_in = S_RESULT;
                     end else begin
                        tsk_we    = 1'b1;
                        tsk_waddr = n_ff[IDX_W-1:0];
                        tsk_wdata = '{rate: req_rate_hz, prio: req_priority_req, elapsed: '0};
                        en_in[n_ff[IDX_W-1:0]] = req_start_enabled;
                        prio_in   = req_priority_req;
                        step_in   = n_ff;
                        state_in  = S_ADD_RD;
                     end
                  end
                  ACT_ENABLE, ACT_DISABLE: begin
                     if (CW'(req_task_number) < CW'(n_ff)) begin
                        en_in[IDX_W'(req_task_number)] = (req_action == ACT_ENABLE);
                        res_in = '{task_id: req_task_number, dispatched: 1'b0,
                                   status: ST_OK, last: 1'b1};
                     end else begin
                        res_in = '{task_id: req_task_number, dispatched: 1'b0,
                                   status: ST_ABSENT, last: 1'b1};
                     end
                     state_in = S_RESULT;
                  end
                  default: begin
                     if (run_ff && (n_ff != '0)) begin
                        step_in   = '0;
                        cnt_in    = '0;
                        pend_v_in = 1'b0;
                        stop_in   = 1'b0;
                        state_in  = S_TK_RD;
                     end
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            if (step_ff == '0) begin
               ord_we    = 1'b1;
               ord_waddr = '0;
               n_in      = n_ff + CNT_W'(1);
               res_in    = '{task_id: TN_W'(n_ff), dispatched: 1'b0, status: ST_OK, last: 1'b1};
               state_in  = S_RESULT;
            end else begin
               ord_raddr = stepm1[IDX_W-1:0];
               state_in  = S_ADD_TK;
            end
         end
         S_ADD_TK: begin
            tsk_raddr = ord_rdata;
            ord_t_in  = ord_rdata;
            state_in  = S_ADD_CMP;
         end
         S_ADD_CMP: begin
            ord_we = 1'b1;
            if (entry.prio >= prio_ff) begin
               ord_wdata = ord_t_ff;
               step_in   = stepm1;
               state_in  = S_ADD_RD;
            end else begin
               n_in     = n_ff + CNT_W'(1);
               res_in   = '{task_id: TN_W'(n_ff), dispatched: 1'b0, status: ST_OK, last: 1'b1};
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               out_req.push = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TK_RD: begin
            state_in = S_TK_TK;
         end
         S_TK_TK: begin
            tsk_raddr = ord_rdata;
            ord_t_in  = ord_rdata;
            state_in  = S_TK_EVAL;
         end
         S_TK_EVAL: begin
            if (!(take && pend_v_ff && !out_free)) begin
               tsk_we = 1'b1;
               if (take) begin
                  tsk_wdata.elapsed = '0;
                  if (pend_v_ff) begin
                     out_req = '{push: 1'b1, data: '{task_id: TN_W'(pend_id_ff),
                                 dispatched: 1'b1, status: ST_OK, last: 1'b0}};
                  end
                  pend_v_in     = 1'b1;
                  pend_id_in    = ord_t_ff;
                  batch_prio_in = entry.prio;
                  cnt_in        = cnt_ff + RES_CNT_W'(1);
               end else if (due) begin
                  stop_in = 1'b1;
               end
               step_in  = step_ff + CNT_W'(1);
               state_in = ((step_ff + CNT_W'(1)) == n_ff) ? S_TK_FLSH : S_TK_RD;
            end
         end
         S_TK_FLSH: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_req   = '{push: 1'b1, data: '{task_id: TN_W'(pend_id_ff),
                             dispatched: 1'b1, status: ST_OK, last: 1'b1}};
               pend_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         n_ff      <= '0;
         en_ff     <= '0;
         run_ff    <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         n_ff      <= n_in;
         en_ff     <= en_in;
         run_ff    <= run_in;
         pend_v_ff <= pend_v_in;
      end
      step_ff       <= step_in;
      pend_id_ff    <= pend_id_in;
      batch_prio_ff <= batch_prio_in;
      stop_ff       <= stop_in;
      cnt_ff        <= cnt_in;
      ord_t_ff      <= ord_t_in;
      prio_ff       <= prio_in;
      res_ff        <= res_in;
   end
endmodule

>>> src/ppd_out.sv
// Result output register between the sequencer and the response channel
module ppd_out (
   input  logic                     clock,
   input  logic                     reset,
   input  ppd_pkg::out_req_type     out_req,
   output logic                     out_free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [ppd_pkg::TN_W-1:0] rsp_task_id,
   output logic                     rsp_dispatched,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);
   import ppd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_req.push) begin
         valid_in = 1'b1;
         data_in  = out_req.data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_task_id    = data_ff.task_id;
   assign rsp_dispatched = data_ff.dispatched;
   assign rsp_status     = data_ff.status;
   assign rsp_last       = data_ff.last;
endmodule

>>> src/priority_periodic_task_dispatcher_core.sv
// Priority periodic task dispatcher, top level
//
// Request channel (req_*): one transfer is one command: add a task, enable or
// disable a task, or a time tick. Response channel (rsp_*): add, enable and
// disable return one transfer each; a tick returns one transfer per dispatched
// task, the final one flagged by rsp_last, or nothing when no task is due or
// csr_write_data last written was 0.
// Enable and disable pass from the request to the result state and then to
// the output register. Add and tick walk the dispatch list entry by entry:
// a read of the order RAM, a read of the task RAM, then compare and write
// back. req_ready is high only in the idle state, so a new request is taken
// only after the previous command is finished.
// Reset clears the installed count, enable bits, run bit and response valid;
// the table RAMs need no clearing pass.
// A stalled response holds its transfer; the sequencer pauses until the
// output register frees, and no result is dropped.
module priority_periodic_task_dispatcher_core #(
   parameter int MAX_TASKS = 8,
   parameter int TICK_MS   = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_action,
   input  logic [ppd_pkg::TN_W-1:0]   req_task_number,
   input  logic [ppd_pkg::RATE_W-1:0] req_rate_hz,
   input  logic [ppd_pkg::PRIO_W-1:0] req_priority_req,
   input  logic                       req_start_enabled,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ppd_pkg::TN_W-1:0]   rsp_task_id,
   output logic                       rsp_dispatched,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_last,
   input  logic                       csr_write_enable,
   input  logic                       csr_write_data
);
   import ppd_pkg::*;

   out_req_type out_req;
   logic        out_free;

   ppd_ctrl #(.MAX_TASKS(MAX_TASKS), .TICK_MS(TICK_MS)) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_task_number   (req_task_number),
      .req_rate_hz       (req_rate_hz),
      .req_priority_req  (req_priority_req),
      .req_start_enabled (req_start_enabled),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .out_free          (out_free),
      .out_req           (out_req)
   );

   ppd_out u_out (
      .clock          (clock),
      .reset          (reset),
      .out_req        (out_req),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_task_id    (rsp_task_id),
      .rsp_dispatched (rsp_dispatched),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );
endmodule

>>> src/ppd_check.sv
// Port-level checker for the dispatcher, bound to the top level
`include "priority_periodic_task_dispatcher_core_assert.svh"

module ppd_check (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [ppd_pkg::TN_W-1:0] rsp_task_id,
   input logic                     rsp_dispatched,
   input logic [1:0]               rsp_status,
   input logic                     rsp_last
);
   import ppd_pkg::*;

   logic            rsp_stall;
   logic [TN_W+3:0] rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_task_id, rsp_dispatched, rsp_status, rsp_last};

   `PPD_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_word))
   `PPD_ASSERT(a_dispatch_ok, clock, reset, rsp_valid && rsp_dispatched |-> rsp_status == ST_OK)
   `PPD_ASSERT(a_single_is_last, clock, reset, rsp_valid && !rsp_dispatched |-> rsp_last)
   `PPD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready)
endmodule

bind priority_periodic_task_dispatcher_core ppd_check u_ppd_check (.*);
